// ===== src/ofmd_pkg.sv =====
// ofmd_pkg: types, codes and fixed offsets for the order feed message decoder
// no dependencies; used by the interfaces, ofmd_capture and order_feed_message_decoder
`default_nettype none

package ofmd_pkg;

    localparam int unsigned POS_W = 6;

    localparam logic [POS_W-1:0] POS_MAX            = 6'd63;
    localparam logic [POS_W-1:0] ORDER_REF_FIRST    = 6'd5;
    localparam logic [POS_W-1:0] ORDER_REF_LAST     = 6'd8;
    localparam logic [POS_W-1:0] SIDE_POS           = 6'd9;
    localparam logic [POS_W-1:0] QUANTITY_FIRST     = 6'd10;
    localparam logic [POS_W-1:0] QUANTITY_LAST      = 6'd15;
    localparam logic [POS_W-1:0] PRICE_FIRST        = 6'd16;
    localparam logic [POS_W-1:0] PRICE_LAST         = 6'd23;
    localparam logic [POS_W-1:0] CONDITION_POS      = 6'd24;
    localparam logic [POS_W-1:0] MODIFICATION_POS   = 6'd25;

    // minimum tag lengths
    localparam logic [POS_W:0] MIN_LEN_ADD     = 7'd26;
    localparam logic [POS_W:0] MIN_LEN_DELETE  = 7'd11;
    localparam logic [POS_W:0] MIN_LEN_EXECUTE = 7'd20;

    localparam logic [7:0] TYPE_ADD     = 8'h41; // 'A'
    localparam logic [7:0] TYPE_DELETE  = 8'h44; // 'D'
    localparam logic [7:0] TYPE_EXECUTE = 8'h45; // 'E'
    localparam logic [7:0] TYPE_EXEC_PX = 8'h43; // 'C'
    localparam logic [7:0] TYPE_RESET   = 8'h52; // 'R'
    localparam logic [7:0] SIDE_CHAR_BUY  = 8'h42; // 'B'
    localparam logic [7:0] SIDE_CHAR_SELL = 8'h53; // 'S'

    localparam logic signed [63:0] PRICE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        KIND_ADD      = 3'd0,
        KIND_DELETE   = 3'd1,
        KIND_EXECUTE  = 3'd2,
        KIND_EXEC_PX  = 3'd3,
        KIND_RESET    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        SIDE_BUY     = 2'd0,
        SIDE_SELL    = 2'd1,
        SIDE_UNKNOWN = 2'd2
    } side_t;

    typedef struct packed {
        logic [7:0] tag_type;
        logic [7:0] data_byte;
        logic       last_byte;
    } tag_item_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [31:0]        order_ref;
        logic [1:0]         side;
        logic [47:0]        quantity;
        logic signed [63:0] price;
        logic [7:0]         cond_code;
        logic [7:0]         mod_code;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] order_ref;
        logic [7:0]  side;
        logic [47:0] quantity;
        logic [63:0] px_raw;
        logic [7:0]  condition;
        logic [7:0]  modification;
    } fields_t;

endpackage

`default_nettype wire

// ===== src/ofmd_if.sv =====
// ofmd_if: valid/ready channel interfaces for tag bytes, messages and configuration
// depends on ofmd_pkg
`default_nettype none

interface ofmd_tag_if;
    logic                 valid;
    logic                 ready;
    ofmd_pkg::tag_item_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ofmd_msg_if;
    logic                 valid;
    logic                 ready;
    ofmd_pkg::msg_item_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ofmd_cfg_if;
    logic                 valid;
    logic                 ready;
    logic signed [63:0]   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/order_feed_message_decoder.sv =====
// order_feed_message_decoder: top level, decodes order-feed tag bytes into messages
// depends on ofmd_pkg, ofmd_if and ofmd_capture
//
//   channel   modport  payload                              transaction
//   tag_in    sink     tag_type, data_byte, last_byte       one tag byte
//   msg_out   source   kind .. mod_code                     one decoded message
//   cfg       sink     market price value (64, signed)      one register write
//
// one tag byte per cycle while tag_in is ready; a message appears on msg_out the cycle after its last byte
// the field captures and the message register sit back to back with no other stage
// tag_in stalls only while a message is held and msg_out is not ready
// reset clears the byte counter, captures, market price and message valid flag; no clearing pass
`default_nettype none

module order_feed_message_decoder (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ofmd_tag_if.sink    tag_in,
    ofmd_msg_if.source  msg_out,
    ofmd_cfg_if.sink    cfg
);

    logic                        accept;
    logic [ofmd_pkg::POS_W-1:0]  position;
    logic [ofmd_pkg::POS_W:0]    tag_len;
    ofmd_pkg::fields_t           fields_next;
    logic signed [63:0]          market_price_reg;
    logic signed [63:0]          price_decoded;
    logic                        msg_valid_reg;
    ofmd_pkg::msg_item_t         msg_reg;
    ofmd_pkg::msg_item_t         msg_next;
    logic                        msg_hit;

    assign tag_in.ready = !msg_valid_reg || msg_out.ready;
    assign accept       = tag_in.valid && tag_in.ready;
    assign cfg.ready    = 1'b1;

    ofmd_capture u_capture (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (tag_in.payload.data_byte),
        .last_byte   (tag_in.payload.last_byte),
        .position    (position),
        .fields_next (fields_next)
    );

    assign tag_len = {1'b0, position} + 1'b1;

    always_comb
    begin
        if (&fields_next.px_raw)
            price_decoded = market_price_reg;
        else if (fields_next.px_raw[63])
            price_decoded = ofmd_pkg::PRICE_MAX;
        else
            price_decoded = $signed(fields_next.px_raw);
    end

    always_comb
    begin
        msg_next = '0;
        msg_hit  = 1'b0;
        case (tag_in.payload.tag_type)
            ofmd_pkg::TYPE_ADD:
            begin
                if (tag_len >= ofmd_pkg::MIN_LEN_ADD)
                begin
                    msg_hit            = 1'b1;
                    msg_next.kind      = ofmd_pkg::KIND_ADD;
                    msg_next.order_ref = fields_next.order_ref;
                    case (fields_next.side)
                        ofmd_pkg::SIDE_CHAR_BUY:  msg_next.side = ofmd_pkg::SIDE_BUY;
                        ofmd_pkg::SIDE_CHAR_SELL: msg_next.side = ofmd_pkg::SIDE_SELL;
                        default:                  msg_next.side = ofmd_pkg::SIDE_UNKNOWN;
                    endcase
                    msg_next.quantity  = fields_next.quantity;
                    msg_next.price     = price_decoded;
                    msg_next.cond_code = fields_next.condition;
                    msg_next.mod_code  = fields_next.modification;
                end
            end
            ofmd_pkg::TYPE_DELETE:
            begin
                if (tag_len >= ofmd_pkg::MIN_LEN_DELETE)
                begin
                    msg_hit            = 1'b1;
                    msg_next.kind      = ofmd_pkg::KIND_DELETE;
                    msg_next.order_ref = fields_next.order_ref;
                end
            end
            ofmd_pkg::TYPE_EXECUTE, ofmd_pkg::TYPE_EXEC_PX:
            begin
                if (tag_len >= ofmd_pkg::MIN_LEN_EXECUTE)
                begin
                    msg_hit            = 1'b1;
                    msg_next.kind      = (tag_in.payload.tag_type == ofmd_pkg::TYPE_EXECUTE)
                                         ? ofmd_pkg::KIND_EXECUTE : ofmd_pkg::KIND_EXEC_PX;
                    msg_next.order_ref = fields_next.order_ref;
                    msg_next.quantity  = fields_next.quantity;
                end
            end
            ofmd_pkg::TYPE_RESET:
            begin
                msg_hit       = 1'b1;
                msg_next.kind = ofmd_pkg::KIND_RESET;
            end
            default:
                msg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            market_price_reg <= '0;
        else if (cfg.valid && cfg.ready)
            market_price_reg <= cfg.payload;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            msg_valid_reg <= 1'b0;
        else if (accept && tag_in.payload.last_byte && msg_hit)
            msg_valid_reg <= 1'b1;
        else if (msg_out.ready)
            msg_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && tag_in.payload.last_byte && msg_hit)
            msg_reg <= msg_next;
    end

    assign msg_out.valid   = msg_valid_reg;
    assign msg_out.payload = msg_reg;

endmodule

`default_nettype wire

// ===== src/ofmd_capture.sv =====
// ofmd_capture: byte position counter and big-endian field capture registers
// depends on ofmd_pkg
`default_nettype none

module ofmd_capture (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              accept,
    input  wire logic [7:0]                        data_byte,
    input  wire logic                              last_byte,
    output logic [ofmd_pkg::POS_W-1:0]             position,
    output ofmd_pkg::fields_t                      fields_next
);

    logic [ofmd_pkg::POS_W-1:0] pos_reg;
    logic [ofmd_pkg::POS_W-1:0] pos_next;
    ofmd_pkg::fields_t          fields_reg;

    assign position = pos_reg;

    always_comb
    begin
        fields_next = fields_reg;
        case (pos_reg) inside
            [ofmd_pkg::ORDER_REF_FIRST:ofmd_pkg::ORDER_REF_LAST]:
                fields_next.order_ref = {fields_reg.order_ref[23:0], data_byte};
            ofmd_pkg::SIDE_POS:
                fields_next.side = data_byte;
            [ofmd_pkg::QUANTITY_FIRST:ofmd_pkg::QUANTITY_LAST]:
                fields_next.quantity = {fields_reg.quantity[39:0], data_byte};
            [ofmd_pkg::PRICE_FIRST:ofmd_pkg::PRICE_LAST]:
                fields_next.px_raw = {fields_reg.px_raw[55:0], data_byte};
            ofmd_pkg::CONDITION_POS:
                fields_next.condition = data_byte;
            ofmd_pkg::MODIFICATION_POS:
                fields_next.modification = data_byte;
            default:
                fields_next = fields_reg;
        endcase
    end

    always_comb
    begin
        if (last_byte)
            pos_next = '0;
        else if (pos_reg == ofmd_pkg::POS_MAX)
            pos_next = pos_reg;
        else
            pos_next = pos_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            fields_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            fields_reg <= fields_next;
        end
    end

endmodule

`default_nettype wire
